// ===== hw/rtl/ple_pkg.sv =====
// shared types and constants for the positional list engine
`default_nettype none
package ple_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;

  // operation codes carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // status codes carried on out_tuser
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // what every cell does at the next edge
  typedef enum logic [1:0] {
    SHIFT_HOLD   = 2'd0,
    SHIFT_INSERT = 2'd1,
    SHIFT_DELETE = 2'd2
  } shift_t;

  // broadcast from the top level to the row of cells
  typedef struct packed {
    shift_t              shift;
    logic [POS_W-1:0]    slot;   // position minus one
    logic [DATA_W-1:0]   value;  // value for the insert slot
  } cell_ctrl_t;

endpackage : ple_pkg
`default_nettype wire

// ===== hw/rtl/ple_cell.sv =====
// one storage cell of the list: holds one entry, shifts with its neighbors
`default_nettype none
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned CELL_INDEX = 0
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] left_value,
  input  wire logic [DATA_W-1:0] right_value,
  output logic      [DATA_W-1:0] value,
  output logic      [DATA_W-1:0] tap
);

  localparam logic [31:0] MY_INDEX = 32'(CELL_INDEX);

  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] value_nxt;
  logic [31:0]       slot_w;
  logic              hit;
  logic              behind;

  assign slot_w = 32'(ctrl.slot);
  assign hit    = (slot_w == MY_INDEX);
  assign behind = (MY_INDEX > slot_w);

  always_comb begin
    value_nxt = value_r;
    case (ctrl.shift)
      SHIFT_INSERT: begin
        if (hit) begin
          value_nxt = ctrl.value;
        end else if (behind) begin
          value_nxt = left_value;
        end
      end
      SHIFT_DELETE: begin
        if (hit || behind) begin
          value_nxt = right_value;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  // read tap, or-ed together across the row
  assign tap   = hit ? value_r : '0;

endmodule : ple_cell
`default_nettype wire

// ===== hw/rtl/positional_list_engine.sv =====
// positional list engine: bounded ordered list held in a row of shifting cells
// the result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while out_tready is high; the whole row
//   of cells shifts in parallel in the cycle the request is accepted
// reset: synchronous active-low rst_n empties the list and drops out_tvalid;
//   cell contents are not reset and are only read below the fill count
`default_nettype none
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // position [6:0], new_value [38:7], zero pad
  input  wire logic [1:0]  in_tuser,   // func [1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // read_value [31:0], list_length [38:32], zero pad
  output logic      [1:0]  out_tuser   // status [1:0]
);

  // fill count holds 0..CAPACITY
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // compare width covering both position and count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request fields
  func_t             req_func;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_value;
  logic              req_accept;

  assign req_func   = func_t'(in_tuser);
  assign req_pos    = in_tdata[POS_W-1:0];
  assign req_value  = in_tdata[POS_W+DATA_W-1:POS_W];
  assign req_accept = in_tvalid && in_tready;

  // list state
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  // result register, which also parts the two sides
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] read_r;
  logic [DATA_W-1:0] read_nxt;
  logic [POS_W-1:0]  length_r;
  logic [POS_W-1:0]  length_nxt;
  status_t           status_r;
  status_t           status_nxt;

  // range checks against the current fill count
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              pos_nz;
  logic              pos_in_list;   // 1..count
  logic              pos_insertable; // 1..count+1
  logic              list_full;

  assign pos_c          = CMP_W'(req_pos);
  assign cnt_c          = CMP_W'(count_r);
  assign pos_nz         = (req_pos != '0);
  assign pos_in_list    = pos_nz && (pos_c <= cnt_c);
  assign pos_insertable = pos_nz && ((pos_c - CMP_W'(1)) <= cnt_c);
  assign list_full      = (count_r == CAP_CNT);

  // row of cells
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_value [CAPACITY];
  logic [DATA_W-1:0] cell_tap   [CAPACITY];
  logic [DATA_W-1:0] tap_or;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (gi == 0) begin : g_first
        // the first cell never takes from its left on insert
        assign left_v = req_value;
      end else begin : g_mid_left
        assign left_v = cell_value[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        // the tail slot becomes unused after a delete
        assign right_v = cell_value[gi];
      end else begin : g_mid_right
        assign right_v = cell_value[gi+1];
      end
      ple_cell #(
        .CELL_INDEX (gi)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .left_value  (left_v),
        .right_value (right_v),
        .value       (cell_value[gi]),
        .tap         (cell_tap[gi])
      );
    end
  endgenerate

  // read bus: only the cell at the addressed slot drives its tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  // decode the request into a shift command and a result
  always_comb begin
    ctrl.shift = SHIFT_HOLD;
    ctrl.slot  = req_pos - POS_W'(1);
    ctrl.value = req_value;
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    read_nxt   = '0;
    unique case (req_func)
      FUNC_GET: begin
        if (pos_in_list) begin
          read_nxt = tap_or;
        end else begin
          status_nxt = STATUS_RANGE;
        end
      end
      FUNC_INSERT: begin
        if (!pos_insertable) begin
          status_nxt = STATUS_RANGE;
        end else if (list_full) begin
          status_nxt = STATUS_FULL;
        end else begin
          ctrl.shift = SHIFT_INSERT;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      FUNC_DELETE: begin
        if (pos_in_list) begin
          read_nxt   = tap_or;
          ctrl.shift = SHIFT_DELETE;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          status_nxt = STATUS_RANGE;
        end
      end
      FUNC_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    // cells move only on an accepted request
    if (!req_accept) begin
      ctrl.shift = SHIFT_HOLD;
      count_nxt  = count_r;
    end
  end

  // length field is the count cut to its port width
  assign length_nxt = POS_W'(count_nxt);

  // a new request may enter whenever the result slot is free or draining
  assign in_tready     = !out_valid_r || out_tready;
  assign out_valid_nxt = req_accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (req_accept) begin
      read_r   <= read_nxt;
      length_r <= length_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, length_r, read_r};
  assign out_tuser  = status_r;

`ifndef NO_ASSERTIONS
  // fill count never passes the capacity
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("fill count above capacity");

  // a clear request reports an empty list
  a_clear_empty : assert property (@(posedge clk) disable iff (!rst_n)
    req_accept && (req_func == FUNC_CLEAR)
      |=> out_valid_r && (length_r == '0) && (status_r == STATUS_OK))
    else $error("clear did not empty the list");

  // a successful insert grows the list by one
  a_insert_grow : assert property (@(posedge clk) disable iff (!rst_n)
    req_accept && (req_func == FUNC_INSERT) && (status_nxt == STATUS_OK)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  // requests are held back only while a result waits
  a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("request side stalled without a pending result");
`endif

endmodule : positional_list_engine
`default_nettype wire
